[hdl/lu_pkg.sv]
`timescale 1ns / 1ps

package lu_pkg;

	localparam int SIZE_DEF  = 8;
	localparam int FRAC_DEF  = 16;
	localparam int DATA_W    = 32;
	localparam int ROW_W     = 3;
	localparam int COL_W     = 4;
	// index width that covers column SIZE for SIZE up to 16
	localparam int IDX_W     = 5;

	// operand selection for one dot product along the cell chain
	typedef struct packed {
		logic [IDX_W-1:0] r;        // row broadcast on the row bus
		logic [IDX_W-1:0] c;        // column each cell takes from its own row
		logic             own_sol;  // cells use their solution entry instead
		logic [IDX_W-1:0] lo;       // first contributing cell
		logic [IDX_W-1:0] hi;       // one past the last contributing cell
	} cmd_t;

	// single write port into the cell storage
	typedef struct packed {
		logic                     en;
		logic                     sol;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [DATA_W-1:0] data;
	} wr_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/lu_linear_solver_top.sv]
`timescale 1ns / 1ps

// Channel    Direction  Handshake             Payload
// request    in         req_valid/req_stall   row, col, value, last
// solution   out        sol_valid/sol_stall   index, solution, final_res, singular
//
// Requests load one matrix or right-hand side element per cycle while the block is idle.
// A request with last starts the solve; req_stall stays high until every solution is out.
// Each dot product runs down the cell chain; each divide runs in the bit-serial divider.
// Reset clears control state only; stored matrix values persist between solves.
// A stalled solution holds its payload; solutions leave in index order.

module lu_linear_solver_top #(
	parameter int SIZE      = lu_pkg::SIZE_DEF,
	parameter int FRAC_BITS = lu_pkg::FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [lu_pkg::ROW_W-1:0]          row,
	input  logic [lu_pkg::COL_W-1:0]          col,
	input  logic signed [lu_pkg::DATA_W-1:0]  value,
	input  logic                              last,
	output logic                              sol_valid,
	input  logic                              sol_stall,
	output logic [lu_pkg::ROW_W-1:0]          index,
	output logic signed [lu_pkg::DATA_W-1:0]  solution,
	output logic                              final_res,
	output logic                              singular
);

	localparam int RW    = $clog2(SIZE);
	localparam int CW    = $clog2(SIZE + 1);
	localparam int CNT_W = $clog2(SIZE + 3);
	localparam int ACC_W = 32 + $clog2(SIZE);
	localparam int IW    = lu_pkg::IDX_W;

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_START = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// factor U row, factor L column, forward and backward substitution
	typedef enum logic [3:0] {
		PH_U   = 4'b0001,
		PH_L   = 4'b0010,
		PH_FWD = 4'b0100,
		PH_BWD = 4'b1000
	} phase_t;

	state_t                     state_q;
	phase_t                     phase_q;
	logic [IW-1:0]              i_q;
	logic [IW-1:0]              k_q;
	logic [IW-1:0]              e_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       flag_q;
	logic signed [31:0]         piv_q;
	lu_pkg::cmd_t               cmd_q;
	lu_pkg::cmd_t               cmd_d;
	lu_pkg::wr_t                wr;

	logic signed [31:0]         row_all [SIZE][SIZE+1];
	logic signed [31:0]         sol_all [SIZE];
	logic signed [31:0]         row_bus [SIZE+1];
	logic signed [ACC_W-1:0]    psum_chain [SIZE+1];

	logic                       load_acc;
	logic                       load_wr;
	logic                       wait_end;
	logic                       is_div_ph;
	logic signed [31:0]         piv;
	logic                       piv_zero;
	logic                       op_done;
	logic signed [31:0]         base;
	logic signed [31:0]         diff;
	logic signed [31:0]         res;
	logic                       div_start;
	logic                       div_done;
	logic signed [31:0]         quo;
	logic                       last_i;
	logic                       last_k;

	assign req_stall = (state_q != ST_LOAD);
	assign load_acc  = req_valid && !req_stall;
	// drop elements that address nothing
	assign load_wr   = load_acc && (IW'(row) < IW'(SIZE)) && (IW'(col) <= IW'(SIZE));

	assign last_i    = (i_q == IW'(SIZE - 1));
	assign last_k    = (k_q == IW'(SIZE - 1));
	assign wait_end  = (state_q == ST_WAIT) && (cnt_q == '0);
	assign is_div_ph = (phase_q == PH_L) || (phase_q == PH_BWD);

	// the row bus carries the selected row to every cell
	always_comb begin
		for (int x = 0; x < SIZE + 1; x++) begin
			row_bus[x] = row_all[cmd_q.r[RW-1:0]][x];
		end
	end

	// pivot: latched from U while factoring, read off the row bus in back substitution
	assign piv      = (phase_q == PH_BWD) ? row_bus[i_q[CW-1:0]] : piv_q;
	assign piv_zero = (piv == '0);

	always_comb begin
		unique case (phase_q)
			PH_U, PH_L: base = row_bus[cmd_q.c[CW-1:0]];
			PH_FWD:     base = row_bus[SIZE];
			PH_BWD:     base = sol_all[i_q[RW-1:0]];
			default:    base = '0;
		endcase
	end

	assign diff      = lu_pkg::sat32(64'(base) - 64'(psum_chain[SIZE]));
	assign op_done   = (wait_end && (!is_div_ph || piv_zero)) ||
	                   ((state_q == ST_DIV) && div_done);
	assign res       = (state_q == ST_DIV) ? quo : (is_div_ph ? 32'sd0 : diff);
	assign div_start = wait_end && is_div_ph && !piv_zero;

	// operands for the next dot product
	always_comb begin
		cmd_d = '0;
		unique case (phase_q)
			PH_U: begin
				cmd_d.r  = i_q;
				cmd_d.c  = k_q;
				cmd_d.hi = i_q;
			end
			PH_L: begin
				cmd_d.r  = k_q;
				cmd_d.c  = i_q;
				cmd_d.hi = i_q;
			end
			PH_FWD: begin
				cmd_d.r       = i_q;
				cmd_d.c       = i_q;
				cmd_d.own_sol = 1'b1;
				cmd_d.hi      = i_q;
			end
			PH_BWD: begin
				cmd_d.r       = i_q;
				cmd_d.c       = i_q;
				cmd_d.own_sol = 1'b1;
				cmd_d.lo      = i_q + 1'b1;
				cmd_d.hi      = IW'(SIZE);
			end
			default: cmd_d = '0;
		endcase
	end

	// one write port: loading, or the element just finished
	always_comb begin
		wr = '0;
		if (load_wr) begin
			wr.en   = 1'b1;
			wr.row  = IW'(row);
			wr.col  = IW'(col);
			wr.data = value;
		end else if (op_done) begin
			wr.en   = 1'b1;
			wr.sol  = (phase_q == PH_FWD) || (phase_q == PH_BWD);
			wr.row  = (phase_q == PH_L) ? k_q : i_q;
			wr.col  = (phase_q == PH_U) ? k_q : i_q;
			wr.data = res;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			cmd_q <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_U;
			i_q     <= '0;
			k_q     <= '0;
			e_q     <= '0;
			cnt_q   <= '0;
			flag_q  <= 1'b0;
			piv_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (load_acc && last) begin
						flag_q  <= 1'b0;
						phase_q <= PH_U;
						i_q     <= '0;
						k_q     <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					cnt_q   <= CNT_W'(SIZE + 2);
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
				end
				ST_EMIT: begin
					if (sol_valid && !sol_stall) begin
						if (final_res) begin
							state_q <= ST_LOAD;
						end else begin
							e_q <= e_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase

			// a zero divisor skips the divider and marks the system singular
			if (wait_end && is_div_ph && piv_zero) begin
				flag_q <= 1'b1;
			end

			// advance the loop indices after each finished element
			if (op_done) begin
				state_q <= ST_START;
				unique case (phase_q)
					PH_U: begin
						if (k_q == i_q) begin
							piv_q <= res;
							if (res == '0) begin
								flag_q <= 1'b1;
							end
						end
						if (last_k) begin
							if (last_i) begin
								phase_q <= PH_FWD;
								i_q     <= '0;
							end else begin
								phase_q <= PH_L;
								k_q     <= i_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					PH_L: begin
						if (last_k) begin
							phase_q <= PH_U;
							i_q     <= i_q + 1'b1;
							k_q     <= i_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					PH_FWD: begin
						if (last_i) begin
							phase_q <= PH_BWD;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
					PH_BWD: begin
						if (i_q == '0) begin
							state_q <= ST_EMIT;
							e_q     <= '0;
						end else begin
							i_q <= i_q - 1'b1;
						end
					end
					default: phase_q <= PH_U;
				endcase
			end
		end
	end

	assign psum_chain[0] = '0;

	for (genvar g = 0; g < SIZE; g++) begin : g_cell
		lu_cell #(
			.SIZE      (SIZE),
			.FRAC_BITS (FRAC_BITS),
			.J         (g)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd_q),
			.wr       (wr),
			.row_bus  (row_bus),
			.psum_in  (psum_chain[g]),
			.row_out  (row_all[g]),
			.sol_out  (sol_all[g]),
			.psum_out (psum_chain[g+1])
		);
	end

	lu_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (diff),
		.den    (piv),
		.done   (div_done),
		.quo    (quo)
	);

	assign sol_valid = (state_q == ST_EMIT);
	assign index     = e_q[lu_pkg::ROW_W-1:0];
	assign solution  = sol_all[e_q[RW-1:0]];
	assign final_res = (e_q == IW'(SIZE - 1));
	assign singular  = flag_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid |-> req_stall)
		else $error("request accepted while solutions are pending");

	a_emit_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(sol_valid && !sol_stall && !final_res) |=> sol_valid)
		else $error("solution run ended early");

	a_flag_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(sol_valid && $past(sol_valid)) |-> $stable(singular))
		else $error("singular flag changed during a run");

endmodule

[hdl/lu_cell.sv]
`timescale 1ns / 1ps

module lu_cell #(
	parameter int SIZE      = lu_pkg::SIZE_DEF,
	parameter int FRAC_BITS = lu_pkg::FRAC_DEF,
	parameter int J         = 0
) (
	input  logic                            clk,
	input  lu_pkg::cmd_t                    cmd,
	input  lu_pkg::wr_t                     wr,
	input  logic signed [lu_pkg::DATA_W-1:0] row_bus [SIZE+1],
	input  logic signed [31+$clog2(SIZE):0] psum_in,
	output logic signed [lu_pkg::DATA_W-1:0] row_out [SIZE+1],
	output logic signed [lu_pkg::DATA_W-1:0] sol_out,
	output logic signed [31+$clog2(SIZE):0] psum_out
);

	localparam int ACC_W = 32 + $clog2(SIZE);
	localparam int CW    = $clog2(SIZE + 1);
	localparam int IW    = lu_pkg::IDX_W;

	logic signed [lu_pkg::DATA_W-1:0] row_q [SIZE+1];
	logic signed [lu_pkg::DATA_W-1:0] sol_q;
	logic signed [lu_pkg::DATA_W-1:0] own;
	logic                             en;
	logic                             en_s1;
	logic signed [63:0]               mul_s1;
	logic signed [lu_pkg::DATA_W-1:0] term_s2;
	logic signed [ACC_W-1:0]          psum_q;

	// store this cell's row and solution entry
	always_ff @(posedge clk) begin
		if (wr.en && wr.row == IW'(J)) begin
			if (wr.sol) begin
				sol_q <= wr.data;
			end else begin
				row_q[wr.col[CW-1:0]] <= wr.data;
			end
		end
	end

	assign en  = (IW'(J) >= cmd.lo) && (IW'(J) < cmd.hi);
	assign own = cmd.own_sol ? sol_q : row_q[cmd.c[CW-1:0]];

	// multiply, scale and saturate, then add into the passing partial sum
	always_ff @(posedge clk) begin
		mul_s1  <= 64'(row_bus[J]) * 64'(own);
		en_s1   <= en;
		term_s2 <= en_s1 ? lu_pkg::sat32(mul_s1 >>> FRAC_BITS) : '0;
		psum_q  <= psum_in + ACC_W'(term_s2);
	end

	assign row_out  = row_q;
	assign sol_out  = sol_q;
	assign psum_out = psum_q;

endmodule

[hdl/lu_div.sv]
`timescale 1ns / 1ps

module lu_div #(
	parameter int FRAC_BITS = lu_pkg::FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [lu_pkg::DATA_W-1:0] num,
	input  logic signed [lu_pkg::DATA_W-1:0] den,
	output logic                             done,
	output logic signed [lu_pkg::DATA_W-1:0] quo
);

	localparam int NW    = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    dvd_q;
	logic [31:0]      rem_q;
	logic [31:0]      dmag_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      nmag;
	logic [32:0]      dmag;
	logic [32:0]      rem_sh;
	logic             ge;
	logic [32:0]      rem_sub;
	logic signed [63:0] qs;

	assign nmag    = num[31] ? -33'(num) : 33'(num);
	assign dmag    = den[31] ? -33'(den) : 33'(den);
	assign rem_sh  = {rem_q, dvd_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, dmag_q};
	assign rem_sub = rem_sh - {1'b0, dmag_q};

	// restoring division on magnitudes, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {nmag[31:0], {FRAC_BITS{1'b0}}};
			dmag_q <= dmag[31:0];
			neg_q  <= num[31] ^ den[31];
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
			dvd_q <= {dvd_q[NW-2:0], ge};
		end
	end

	assign qs   = neg_q ? -$signed(64'(dvd_q)) : $signed(64'(dvd_q));
	assign quo  = lu_pkg::sat32(qs);
	assign done = done_q;

endmodule
